// ----- design/fes_pkg.sv -----
// shared types and constants for the frame event scheduler
package fes_pkg;

  localparam int unsigned SlotsDefault = 16;
  localparam int unsigned FrameW       = 32;
  localparam int unsigned KindW        = 3;

  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  typedef enum logic [KindW-1:0] {
    KIND_ACE    = 3'd0,
    KIND_NORMAL = 3'd1,
    KIND_SOFT   = 3'd2,
    KIND_HARD   = 3'd3,
    KIND_RUMBLE = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ACT_NONE   = 3'd0,
    ACT_MODE   = 3'd1,
    ACT_SOFT   = 3'd2,
    ACT_HARD   = 3'd3,
    ACT_RUMBLE = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [FrameW-1:0] frame;
    logic [KindW-1:0]  kind;
  } entry_t;

endpackage

// ----- design/fes_if.sv -----
// valid/ready channel interfaces for input and result words
interface fes_in_if
  import fes_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              op;
  logic [FrameW-1:0] event_frame;
  logic [KindW-1:0]  event_kind;

  modport source (output valid, output op, output event_frame, output event_kind,
                  input ready);
  modport sink (input valid, input op, input event_frame, input event_kind,
                output ready);
endinterface

interface fes_out_if
  import fes_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              added_ok;
  logic [2:0]        action;
  logic              fix_flag;
  logic [FrameW-1:0] frame_now;

  modport source (output valid, output added_ok, output action, output fix_flag,
                  output frame_now, input ready);
  modport sink (input valid, input added_ok, input action, input fix_flag,
                input frame_now, output ready);
endinterface

// ----- design/frame_event_scheduler_core.sv -----
// frame event scheduler: ring of event slots, frame counter and mode flag
// Each accepted word is captured in the idle state. In the scan state the ring
// of slot cells makes one full rotation past the head cell, where the add or
// tick logic looks at one slot per cycle, and the emit state then loads the
// result register once it is free. A new word is accepted once the previous one
// has reached the result register, even while that result still waits to be
// taken. Reset clears all slots at once, so no clearing pass is needed.
module frame_event_scheduler_core
  import fes_pkg::*;
#(
  parameter int unsigned SLOTS = SlotsDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  fes_in_if.sink    in_i,
  fes_out_if.source out_o
);

  localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(SLOTS - 1);

  state_e state_q, state_d;
  logic [IdxW-1:0]   cnt_q, cnt_d;
  logic              op_q;
  logic [FrameW-1:0] frame_in_q;
  logic [KindW-1:0]  kind_in_q;
  logic              hit_q, hit_d;
  logic              stop_q, stop_d;
  logic [2:0]        action_q, action_d;
  logic              mode_q, mode_d;
  logic [FrameW-1:0] frame_cnt_q;

  logic              out_valid_q;
  logic              out_added_ok_q;
  logic [2:0]        out_action_q;
  logic              out_fix_flag_q;
  logic [FrameW-1:0] out_frame_now_q;

  logic   in_acc;
  logic   shift;
  logic   out_load;
  entry_t head;
  entry_t tail_in;
  entry_t ring [SLOTS];

  // ring of cells, head at index 0, tail refilled from the head or, on an add, with the new event
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    entry_t nxt;
    if (i == SLOTS - 1) begin : g_tail
      assign nxt = tail_in;
    end else begin : g_mid
      assign nxt = ring[i+1];
    end
    fes_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .shift_i(shift),
      .entry_i(nxt),
      .entry_o(ring[i])
    );
  end

  assign head     = ring[0];
  assign in_acc   = in_i.valid && in_i.ready;
  assign shift    = (state_q == ST_SCAN);
  assign out_load = (state_q == ST_EMIT) && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    hit_d    = hit_q;
    stop_d   = stop_q;
    action_d = action_q;
    mode_d   = mode_q;
    tail_in  = head;
    in_i.ready = (state_q == ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d  = ST_SCAN;
          cnt_d    = '0;
          hit_d    = 1'b0;
          stop_d   = 1'b0;
          action_d = ACT_NONE;
        end
      end
      ST_SCAN: begin
        if (op_q == OP_ADD) begin
          if (!hit_q && (head.frame == '0)) begin
            tail_in.frame = frame_in_q;
            tail_in.kind  = kind_in_q;
            hit_d         = 1'b1;
          end
        end else if (!hit_q && !stop_q) begin
          if (head.frame == '0) begin
            stop_d = 1'b1;
          end else if (head.frame == frame_cnt_q) begin
            unique case (head.kind)
              KIND_ACE: begin
                action_d = ACT_MODE;
                mode_d   = 1'b0;
                hit_d    = 1'b1;
              end
              KIND_NORMAL: begin
                action_d = ACT_MODE;
                mode_d   = 1'b1;
                hit_d    = 1'b1;
              end
              KIND_SOFT: begin
                action_d = ACT_SOFT;
                hit_d    = 1'b1;
              end
              KIND_HARD: begin
                action_d = ACT_HARD;
                hit_d    = 1'b1;
              end
              KIND_RUMBLE: begin
                action_d = ACT_RUMBLE;
                hit_d    = 1'b1;
              end
              default: begin
              end
            endcase
          end
        end
        if (cnt_q == LastIdx) begin
          state_d = ST_EMIT;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_EMIT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      hit_q       <= 1'b0;
      stop_q      <= 1'b0;
      action_q    <= ACT_NONE;
      mode_q      <= 1'b0;
      frame_cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      hit_q    <= hit_d;
      stop_q   <= stop_d;
      action_q <= action_d;
      mode_q   <= mode_d;
      if (in_acc && (in_i.op == OP_TICK)) begin
        frame_cnt_q <= frame_cnt_q + 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // word capture and result register
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q       <= in_i.op;
      frame_in_q <= in_i.event_frame;
      kind_in_q  <= in_i.event_kind;
    end
    if (out_load) begin
      out_added_ok_q  <= (op_q == OP_ADD) && hit_q;
      out_action_q    <= (op_q == OP_TICK) ? action_q : ACT_NONE;
      out_fix_flag_q  <= mode_q;
      out_frame_now_q <= frame_cnt_q;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.added_ok  = out_added_ok_q;
  assign out_o.action    = out_action_q;
  assign out_o.fix_flag  = out_fix_flag_q;
  assign out_o.frame_now = out_frame_now_q;

  a_scan_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && cnt_q == LastIdx) |=> (state_q == ST_EMIT))
    else $error("scan did not end after a full rotation");

  a_tick_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_i.op == OP_TICK) |=> (frame_cnt_q == $past(frame_cnt_q) + 1'b1))
    else $error("frame counter did not advance on tick");

  a_stop_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && op_q == OP_TICK && stop_q) |=> !$rose(hit_q))
    else $error("tick matched past an empty slot");

  a_out_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_added_ok_q) |-> (out_action_q == ACT_NONE))
    else $error("result has both add status and action");

endmodule

// ----- design/fes_cell.sv -----
// one slot of the rotating event ring
module fes_cell
  import fes_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   shift_i,
  input  entry_t entry_i,
  output entry_t entry_o
);

  entry_t entry_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else if (shift_i) begin
      entry_q <= entry_i;
    end
  end

  assign entry_o = entry_q;

endmodule
